// ===== hdl/e2d_pkg.sv =====
// ============================================================================
// e2d_pkg: shared types, constants and functions of the epoch to date block
// Field widths, calendar and time-of-day constants, the fixed-point
// reciprocals that replace the constant divisions, and the year-start helper.
// ============================================================================
package e2d_pkg;

	// Port field widths.
	localparam int MS_W   = 48;
	localparam int YEAR_W = 12;
	localparam int DOY_W  = 9;
	localparam int MON_W  = 4;
	localparam int DOM_W  = 5;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEC_W  = 6;
	localparam int MSEC_W = 10;

	// Default supported year span.
	localparam int MIN_YEAR_DEF = 1900;
	localparam int MAX_YEAR_DEF = 2099;
	localparam int EPOCH_YEAR   = 1970;

	// One day is 2^10 * 84375 milliseconds.
	localparam longint MS_PER_DAY = 86400000;
	localparam int DAY_SHIFT      = 10;
	localparam int DAY_ODD        = 84375;
	localparam int DAY_ODD_W      = 17;
	localparam int TOD_W          = DAY_ODD_W + DAY_SHIFT;

	localparam int MS_PER_SEC  = 1000;
	localparam int SEC_PER_MIN = 60;
	localparam int MIN_PER_HR  = 60;

	// Days since 0001-01-01 fit in this many bits for any legal year span.
	localparam int D1_W = 21;

	// Gregorian cycle lengths in days.
	localparam int DAYS_400Y = 146097;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_4Y   = 1461;
	localparam int DAYS_1Y   = 365;

	// Exact reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s for an N-bit x,
	// with s = N + ceil(log2(d)).
	localparam int SH_400 = 39;
	localparam logic [21:0] RCP_400 =
		22'(((64'd1 << SH_400) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
	localparam int SH_100 = 34;
	localparam logic [18:0] RCP_100 =
		19'(((64'd1 << SH_100) + 64'(DAYS_100Y) - 64'd1) / 64'(DAYS_100Y));
	localparam int SH_4 = 27;
	localparam logic [16:0] RCP_4 =
		17'(((64'd1 << SH_4) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
	localparam int SH_1 = 20;
	localparam logic [11:0] RCP_1 =
		12'(((64'd1 << SH_1) + 64'(DAYS_1Y) - 64'd1) / 64'(DAYS_1Y));

	// Time of day: seconds = (tod >> 3) / 125, minutes = (tod >> 5) / 1875,
	// hours = (tod >> 7) / 28125.
	localparam int SH_SEC = 31;
	localparam logic [24:0] RCP_SEC = 25'(((64'd1 << SH_SEC) + 64'd124) / 64'd125);
	localparam int SH_MIN = 33;
	localparam logic [22:0] RCP_MIN = 23'(((64'd1 << SH_MIN) + 64'd1874) / 64'd1875);
	localparam int SH_HOUR = 35;
	localparam logic [20:0] RCP_HOUR = 21'(((64'd1 << SH_HOUR) + 64'd28124) / 64'd28125);

	// Sideband that travels with a day split through the divider.
	typedef struct packed {
		logic                 vld;
		logic                 oor;
		logic [DAY_SHIFT-1:0] ms_lo;
	} day_tag_t;

	// Leap years in 1 .. y-1, for y >= 1.
	function automatic longint leaps_before(input longint y);
		longint p;
		p = y - 1;
		return p / 4 - p / 100 + p / 400;
	endfunction

	// Days from 1970-01-01 to January 1 of year y, for y >= 1.
	function automatic longint year_start(input longint y);
		return 365 * (y - EPOCH_YEAR) + leaps_before(y) - leaps_before(EPOCH_YEAR);
	endfunction

	// Days of the year that precede month m (1..12).
	function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DOY_W-1:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ===== hdl/e2d_day_div.sv =====
// ============================================================================
// e2d_day_div: three-stage division by the odd part of one day
// A reciprocal multiply gives a quotient that is at most one short. The
// remainder that goes with it and one compare and subtract then settle both.
// The tag rides along.
// ============================================================================
module e2d_day_div #(
	parameter int NUM_W = 34,
	parameter int QUO_W = 17
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  e2d_pkg::day_tag_t               tag_in,
	input  logic [NUM_W-1:0]                num,
	output e2d_pkg::day_tag_t               tag_out,
	output logic [QUO_W-1:0]                quo,
	output logic [e2d_pkg::DAY_ODD_W-1:0]   rem
);
	import e2d_pkg::*;

	// The estimate uses only the numerator bits from LO_CUT up. The divisor is
	// above 2^16, so the dropped bits and the truncated reciprocal together
	// cost less than one in the quotient, and the estimate never runs over.
	localparam int LO_CUT = 15;
	localparam int XW     = NUM_W - LO_CUT;
	localparam int PW     = 2 * XW;
	localparam logic [XW-1:0] RCP =
		XW'((64'd1 << (NUM_W + 1)) / 64'(DAY_ODD));
	// The remainder of the estimate is below twice the divisor.
	localparam int RW = DAY_ODD_W + 1;

	logic [PW-1:0] prod;
	logic [RW-1:0] part;
	logic ge;
	day_tag_t tag_s1, tag_s2, tag_s3;
	logic [NUM_W-1:0] num_s1;
	logic [QUO_W-1:0] est_s1, est_s2;
	logic [RW-1:0] rem_s2;
	logic [QUO_W-1:0] quo_s3;
	logic [DAY_ODD_W-1:0] rem_s3;

	always_comb begin
		prod = PW'(num[NUM_W-1:LO_CUT]) * PW'(RCP);
		part = RW'(num_s1 - NUM_W'(est_s1) * NUM_W'(DAY_ODD));
		ge   = rem_s2 >= RW'(DAY_ODD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= num;
			est_s1 <= prod[XW+1 +: QUO_W];
			est_s2 <= est_s1;
			rem_s2 <= part;
			quo_s3 <= est_s2 + QUO_W'(ge);
			rem_s3 <= ge ? DAY_ODD_W'(rem_s2 - RW'(DAY_ODD)) : rem_s2[DAY_ODD_W-1:0];
		end
	end

	assign tag_out = tag_s3;
	assign quo     = quo_s3;
	assign rem     = rem_s3;

endmodule

// ===== hdl/e2d_civil.sv =====
// ============================================================================
// e2d_civil: day count and time of day to calendar fields
// Splits days into Gregorian 400, 100, 4 and 1 year cycles, finds the month,
// and breaks the time of day into hours, minutes, seconds and milliseconds.
// ============================================================================
module e2d_civil #(
	parameter int MIN_YEAR = e2d_pkg::MIN_YEAR_DEF,
	parameter int QUO_W    = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  e2d_pkg::day_tag_t             tag,
	input  logic [QUO_W-1:0]              quo,
	input  logic [e2d_pkg::DAY_ODD_W-1:0] rem,
	output logic                          date_valid,
	output logic [e2d_pkg::YEAR_W-1:0]    year,
	output logic [e2d_pkg::DOY_W-1:0]     day_of_year,
	output logic [e2d_pkg::MON_W-1:0]     month,
	output logic [e2d_pkg::DOM_W-1:0]     day_of_month,
	output logic [e2d_pkg::HOUR_W-1:0]    hour,
	output logic [e2d_pkg::MIN_W-1:0]     minute,
	output logic [e2d_pkg::SEC_W-1:0]     second,
	output logic [e2d_pkg::MSEC_W-1:0]    millisecond,
	output logic                          out_of_range
);
	import e2d_pkg::*;

	localparam int NSTG = 11;
	// Days from 0001-01-01 to January 1 of the first supported year.
	localparam logic [D1_W-1:0] DAY0 =
		D1_W'(year_start(longint'(MIN_YEAR)) - year_start(longint'(1)));

	typedef struct packed {
		logic [HOUR_W-1:0] hr;
		logic [MIN_W-1:0]  mn;
		logic [SEC_W-1:0]  sc;
		logic [MSEC_W-1:0] ms;
	} tod_t;

	logic [NSTG:1] vld_s;
	logic [NSTG-1:1] oor_s;
	tod_t tm_s [2:NSTG-1];

	// Stage 1.
	logic [TOD_W-1:0] tod;
	logic [48:0] sec_prod;
	logic [44:0] min_prod;
	logic [40:0] hr_prod;
	logic [D1_W-1:0] d_s1;
	logic [TOD_W-1:0] tod_s1;
	logic [16:0] secq_s1;
	logic [10:0] minq_s1;
	logic [HOUR_W-1:0] hrq_s1;
	// Stage 2.
	logic [42:0] p400;
	logic [D1_W-1:0] d_s2;
	logic [3:0] n400_s2;
	// Stages 3 to 9.
	logic [17:0] r1_s3, r1_s4;
	logic [YEAR_W-1:0] yr_s3, yr_s4, yr_s5, yr_s6, yr_s7, yr_s8;
	logic [36:0] p100;
	logic [2:0] n100_s4;
	logic [1:0] n100c;
	logic [15:0] r2_s5, r2_s6;
	logic c400_s5, c400_s6;
	logic [32:0] p4;
	logic [4:0] n4_s6;
	logic [10:0] r3_s7, r3_s8;
	logic lok_s7, lok_s8;
	logic [22:0] p1;
	logic [2:0] n1_s8;
	logic [1:0] n1c;
	logic [DOY_W-1:0] doy_s9, doy_s10;
	logic [YEAR_W-1:0] year_s9, year_s10;
	logic leap_s9, leap_s10;
	// Stages 10 and 11.
	logic [MON_W-1:0] mon_cnt;
	logic [MON_W-1:0] mon_s10;
	logic [YEAR_W-1:0] year_s11;
	logic [DOY_W-1:0] doy_s11;
	logic [MON_W-1:0] mon_s11;
	logic [DOM_W-1:0] dom_s11;
	tod_t tm_s11;
	logic oor_s11;

	always_comb begin
		tod      = {rem, tag.ms_lo};
		sec_prod = 49'(tod[TOD_W-1:3]) * 49'(RCP_SEC);
		min_prod = 45'(tod[TOD_W-1:5]) * 45'(RCP_MIN);
		hr_prod  = 41'(tod[TOD_W-1:7]) * 41'(RCP_HOUR);
		p400     = 43'(d_s1) * 43'(RCP_400);
		p100     = 37'(r1_s3) * 37'(RCP_100);
		p4       = 33'(r2_s5) * 33'(RCP_4);
		p1       = 23'(r3_s7) * 23'(RCP_1);
		// The last day of a 400 year cycle, and of a 4 year cycle, yields
		// a quotient of four; it belongs to the last cycle, number three.
		n100c    = (n100_s4 == 3'd4) ? 2'd3 : n100_s4[1:0];
		n1c      = (n1_s8 == 3'd4) ? 2'd3 : n1_s8[1:0];
		mon_cnt  = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (doy_s9 > days_before(MON_W'(i), leap_s9)) begin
				mon_cnt = mon_cnt + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-1:1], tag.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s <= {oor_s[NSTG-2:1], tag.oor};

			d_s1    <= D1_W'(quo) + DAY0;
			tod_s1  <= tod;
			secq_s1 <= sec_prod[47:SH_SEC];
			minq_s1 <= min_prod[43:SH_MIN];
			hrq_s1  <= hr_prod[39:SH_HOUR];

			d_s2     <= d_s1;
			n400_s2  <= p400[42:SH_400];
			tm_s[2].hr <= hrq_s1;
			tm_s[2].mn <= MIN_W'(minq_s1 - 11'(hrq_s1) * 11'(MIN_PER_HR));
			tm_s[2].sc <= SEC_W'(secq_s1 - 17'(minq_s1) * 17'(SEC_PER_MIN));
			tm_s[2].ms <= MSEC_W'(tod_s1 - TOD_W'(secq_s1) * TOD_W'(MS_PER_SEC));
			for (int k = 3; k < NSTG; k++) begin
				tm_s[k] <= tm_s[k-1];
			end

			r1_s3 <= 18'(d_s2 - D1_W'(n400_s2) * D1_W'(DAYS_400Y));
			yr_s3 <= YEAR_W'(n400_s2) * YEAR_W'(400);

			n100_s4 <= p100[36:SH_100];
			r1_s4   <= r1_s3;
			yr_s4   <= yr_s3;

			r2_s5   <= 16'(r1_s4 - 18'(n100c) * 18'(DAYS_100Y));
			yr_s5   <= yr_s4 + YEAR_W'(n100c) * YEAR_W'(100);
			c400_s5 <= n100c == 2'd3;

			n4_s6   <= p4[31:SH_4];
			r2_s6   <= r2_s5;
			yr_s6   <= yr_s5;
			c400_s6 <= c400_s5;

			// A year that closes a 4 year cycle is leap unless it is a
			// century year outside the last century of its 400 year cycle.
			r3_s7  <= 11'(r2_s6 - 16'(n4_s6) * 16'(DAYS_4Y));
			yr_s7  <= yr_s6 + (YEAR_W'(n4_s6) << 2);
			lok_s7 <= (n4_s6 != 5'd24) || c400_s6;

			n1_s8  <= p1[22:SH_1];
			r3_s8  <= r3_s7;
			yr_s8  <= yr_s7;
			lok_s8 <= lok_s7;

			doy_s9  <= DOY_W'(r3_s8 - 11'(n1c) * 11'(DAYS_1Y)) + 9'd1;
			year_s9 <= yr_s8 + YEAR_W'(n1c) + 12'd1;
			leap_s9 <= (n1c == 2'd3) && lok_s8;

			mon_s10  <= mon_cnt;
			doy_s10  <= doy_s9;
			year_s10 <= year_s9;
			leap_s10 <= leap_s9;

			oor_s11 <= oor_s[NSTG-1];
			if (oor_s[NSTG-1]) begin
				year_s11 <= '0;
				doy_s11  <= '0;
				mon_s11  <= '0;
				dom_s11  <= '0;
				tm_s11   <= '0;
			end else begin
				year_s11 <= year_s10;
				doy_s11  <= doy_s10;
				mon_s11  <= mon_s10;
				dom_s11  <= DOM_W'(doy_s10 - days_before(mon_s10, leap_s10));
				tm_s11   <= tm_s[NSTG-1];
			end
		end
	end

	assign date_valid   = vld_s[NSTG];
	assign year         = year_s11;
	assign day_of_year  = doy_s11;
	assign month        = mon_s11;
	assign day_of_month = dom_s11;
	assign hour         = tm_s11.hr;
	assign minute       = tm_s11.mn;
	assign second       = tm_s11.sc;
	assign millisecond  = tm_s11.ms;
	assign out_of_range = oor_s11;

endmodule

// ===== hdl/epoch_to_datetime.sv =====
// ============================================================================
// epoch_to_datetime: signed epoch milliseconds to Gregorian calendar time
// Fully pipelined converter from a 48-bit millisecond count since
// 1970-01-01 00:00:00.000 to year, day of year, month, day, hour, minute,
// second and millisecond.
// ============================================================================
//
// The block takes one request per clock cycle unless the pipeline holds,
// and returns one result per request, in order. One stage checks the range
// and rebases the count, three divide it by one day (a reciprocal multiply
// that may come out one short, the remainder that goes with it, and one
// compare and subtract that settles both), and the calendar split that
// follows takes eleven stages. Times before 1970 round down to the previous
// day, so the time of day is never negative. A time before January 1 of
// MIN_YEAR or after December 31 of MAX_YEAR sets out_of_range and returns
// zeros in every other field. The whole pipeline holds while a result waits
// under date_stall, so epoch_stall follows date_stall whenever the last
// stage is full.
//
module epoch_to_datetime #(
	parameter int MIN_YEAR = e2d_pkg::MIN_YEAR_DEF,
	parameter int MAX_YEAR = e2d_pkg::MAX_YEAR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              epoch_valid,
	output logic                              epoch_stall,
	input  logic signed [e2d_pkg::MS_W-1:0]   epoch_ms,
	// Result channel.
	output logic                              date_valid,
	input  logic                              date_stall,
	output logic [e2d_pkg::YEAR_W-1:0]        year,
	output logic [e2d_pkg::DOY_W-1:0]         day_of_year,
	output logic [e2d_pkg::MON_W-1:0]         month,
	output logic [e2d_pkg::DOM_W-1:0]         day_of_month,
	output logic [e2d_pkg::HOUR_W-1:0]        hour,
	output logic [e2d_pkg::MIN_W-1:0]         minute,
	output logic [e2d_pkg::SEC_W-1:0]         second,
	output logic [e2d_pkg::MSEC_W-1:0]        millisecond,
	output logic                              out_of_range
);
	import e2d_pkg::*;

	// Supported span in days, and the millisecond bounds that go with it.
	localparam longint SPAN_DAYS = year_start(longint'(MAX_YEAR) + 1)
		- year_start(longint'(MIN_YEAR));
	localparam longint SPAN_MS = SPAN_DAYS * MS_PER_DAY;
	localparam logic signed [MS_W-1:0] LO_MS =
		MS_W'(year_start(longint'(MIN_YEAR)) * MS_PER_DAY);
	localparam logic signed [MS_W-1:0] HI_MS =
		MS_W'(year_start(longint'(MAX_YEAR) + 1) * MS_PER_DAY);

	// Offset count width, day quotient width and divider datapath width.
	localparam int UW = $clog2(SPAN_MS);
	localparam int QW = $clog2(SPAN_DAYS);
	localparam int CW = DAY_ODD_W + QW;

	// The pipeline moves unless a finished result is held back.
	logic adv;
	assign adv         = !date_valid || !date_stall;
	assign epoch_stall = !adv;

	// Stage 1: range check, and the count rebased to January 1 of MIN_YEAR,
	// which makes the day split a plain unsigned division.
	logic oor;
	logic signed [MS_W-1:0] rebased;
	logic vld_s1;
	logic oor_s1;
	logic [UW-1:0] u_s1;

	assign oor     = (epoch_ms < LO_MS) || (epoch_ms >= HI_MS);
	assign rebased = epoch_ms - LO_MS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= epoch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s1 <= oor;
			u_s1   <= oor ? '0 : UW'(rebased);
		end
	end

	// Day split: the low ten bits of the count pass by the divider, since a
	// day is 2^10 times an odd number of milliseconds.
	day_tag_t div_tag_in;
	day_tag_t div_tag_out;
	logic [QW-1:0] div_quo;
	logic [DAY_ODD_W-1:0] div_rem;

	always_comb begin
		div_tag_in.vld   = vld_s1;
		div_tag_in.oor   = oor_s1;
		div_tag_in.ms_lo = u_s1[DAY_SHIFT-1:0];
	end

	e2d_day_div #(
		.NUM_W (CW),
		.QUO_W (QW)
	) u_day_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tag_in  (div_tag_in),
		.num     (CW'(u_s1[UW-1:DAY_SHIFT])),
		.tag_out (div_tag_out),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// Calendar and time-of-day fields; its last stage is the output register.
	e2d_civil #(
		.MIN_YEAR (MIN_YEAR),
		.QUO_W    (QW)
	) u_civil (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.tag          (div_tag_out),
		.quo          (div_quo),
		.rem          (div_rem),
		.date_valid   (date_valid),
		.year         (year),
		.day_of_year  (day_of_year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second),
		.millisecond  (millisecond),
		.out_of_range (out_of_range)
	);

endmodule
